// ----- sv/fpa_pkg.sv -----
// Shared types, operation and error codes, and saturation helper for the
// fixed-point arithmetic unit. No dependencies.
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_GT     = 4'd4,
    OP_LT     = 4'd5,
    OP_GE     = 4'd6,
    OP_LE     = 4'd7,
    OP_EQ     = 4'd8,
    OP_NE     = 4'd9,
    OP_MIN    = 4'd10,
    OP_MAX    = 4'd11,
    OP_INC    = 4'd12,
    OP_DEC    = 4'd13,
    OP_TO_INT = 4'd14
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef struct packed {
    logic [31:0] val;
    logic [1:0]  err;
  } res_t;

  // Apply sign to a magnitude, clamping to the 32-bit signed range.
  // big marks a magnitude already known to lie far outside that range.
  function automatic res_t sat_mag(input logic [33:0] m, input logic neg,
                                   input logic big);
    res_t r;
    r.err = ERR_OK;
    if (neg) begin
      if (big || (m > 34'h080000000)) begin
        r.val = 32'h80000000;
        r.err = ERR_OVERFLOW;
      end else begin
        r.val = 32'(-m);
      end
    end else begin
      if (big || (m > 34'h07FFFFFFF)) begin
        r.val = 32'h7FFFFFFF;
        r.err = ERR_OVERFLOW;
      end else begin
        r.val = m[31:0];
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/fpa_mul.sv -----
// Two-stage rounding multiplier on operand magnitudes.
// Depends on fpa_pkg.
module fpa_mul #(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output fpa_pkg::res_t    res
);

  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic        neg1;
  logic [64:0] sum;
  logic [64:0] shifted;

  assign ma = a[31] ? 32'(-a) : a;
  assign mb = b[31] ? 32'(-b) : b;

  // Stage one: raw product of magnitudes.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    neg1 <= a[31] ^ b[31];
  end

  // Stage two: round half away from zero, then clamp.
  assign sum     = {1'b0, prod} + (65'd1 << (FRAC_BITS - 1));
  assign shifted = sum >> FRAC_BITS;

  always_ff @(posedge clk) begin
    res <= fpa_pkg::sat_mag(shifted[33:0], neg1, |shifted[64:34]);
  end

endmodule

// ----- sv/fpa_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with rounding
// and saturation at the tail. Depends on fpa_pkg.
module fpa_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  output fpa_pkg::res_t res
);

  localparam int NW = 32 + FRAC_BITS;  // dividend width
  localparam int QB = 33;              // quotient bits kept
  localparam int XW = 32 + QB;         // widest shifted divisor

  logic [NW-1:0] rem  [QB+1];
  logic [31:0]   dv   [QB+1];
  logic [QB-1:0] q    [QB+1];
  logic          neg  [QB+1];
  logic          dz   [QB+1];
  logic          big  [QB+1];
  logic          asg  [QB+1];

  logic [31:0]   ma, mb;
  logic [NW-1:0] n;

  assign ma = a[31] ? 32'(-a) : a;
  assign mb = b[31] ? 32'(-b) : b;
  assign n  = {ma, FRAC_BITS'(0)};

  // Entry: flag quotients of 2^33 or more as out of range.
  always_ff @(posedge clk) begin
    rem[0] <= n;
    dv[0]  <= mb;
    q[0]   <= '0;
    neg[0] <= a[31] ^ b[31];
    dz[0]  <= (b == 32'd0);
    asg[0] <= a[31];
    big[0] <= ({(XW - NW)'(0), n} >= {mb, QB'(0)});
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    localparam int K = QB - 1 - i;
    logic [XW-1:0] dsh;
    logic          ge;
    assign dsh = {QB'(0), dv[i]} << K;
    assign ge  = ({(XW - NW)'(0), rem[i]} >= dsh);
    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? (rem[i] - dsh[NW-1:0]) : rem[i];
      q[i+1]   <= q[i] | (ge ? (QB'(1) << K) : QB'(0));
      dv[i+1]  <= dv[i];
      neg[i+1] <= neg[i];
      dz[i+1]  <= dz[i];
      big[i+1] <= big[i];
      asg[i+1] <= asg[i];
    end
  end

  // Tail: round on twice the remainder, then clamp.
  logic        rnd;
  logic [33:0] qr;
  assign rnd = ({rem[QB], 1'b0} >= {1'b0, NW'(dv[QB])});
  assign qr  = {1'b0, q[QB]} + 34'(rnd);

  always_ff @(posedge clk) begin
    if (dz[QB]) begin
      res.val <= asg[QB] ? 32'h80000000 : 32'h7FFFFFFF;
      res.err <= fpa_pkg::ERR_DIV_ZERO;
    end else begin
      res <= fpa_pkg::sat_mag(qr, neg[QB], big[QB]);
    end
  end

endmodule

// ----- sv/fixed_point_alu_q24_8_top.sv -----
// Fixed-point arithmetic unit top level: input register, simple-op path,
// multiplier and divider pipes, result register. Depends on fpa_pkg,
// fpa_mul, fpa_div.
// Throughput: one beat per cycle; busy is always low, the 35-stage divider
// pipe sets the latency. Synchronous active-high rst clears valid bits only.
module fixed_point_alu_q24_8_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  op,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        done,
  output logic [31:0] result_value,
  output logic        compare_flag,
  output logic [1:0]  error_code
);

  localparam int DLY = 35;  // divider pipe depth after the input register
  localparam int MUL_LAT = 2;

  // Never stall: every stage advances each cycle.
  assign busy = 1'b0;

  // Input register; hold the beat for the pipes.
  logic        v0;
  logic [3:0]  op0;
  logic [31:0] a0, b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    op0 <= op;
    a0  <= operand_a;
    b0  <= operand_b;
  end

  // Simple ops: wrap arithmetic, compares, select, shift.
  logic [31:0] sval;
  logic        sflag;
  logic        lt_ab, lt_ba;

  assign lt_ab = $signed(a0) < $signed(b0);
  assign lt_ba = $signed(b0) < $signed(a0);

  always_comb begin
    sval  = '0;
    sflag = 1'b0;
    case (fpa_pkg::op_t'(op0))
      fpa_pkg::OP_ADD:    sval  = a0 + b0;
      fpa_pkg::OP_SUB:    sval  = a0 - b0;
      fpa_pkg::OP_GT:     sflag = lt_ba;
      fpa_pkg::OP_LT:     sflag = lt_ab;
      fpa_pkg::OP_GE:     sflag = !lt_ab;
      fpa_pkg::OP_LE:     sflag = !lt_ba;
      fpa_pkg::OP_EQ:     sflag = (a0 == b0);
      fpa_pkg::OP_NE:     sflag = (a0 != b0);
      fpa_pkg::OP_MIN:    sval  = lt_ab ? a0 : b0;
      fpa_pkg::OP_MAX:    sval  = lt_ba ? a0 : b0;
      fpa_pkg::OP_INC:    sval  = a0 + 32'd1;
      fpa_pkg::OP_DEC:    sval  = a0 - 32'd1;
      fpa_pkg::OP_TO_INT: sval  = 32'($signed(a0) >>> FRAC_BITS);
      default: begin
        sval  = '0;
        sflag = 1'b0;
      end
    endcase
  end

  // Side pipe: valid, op and simple result ride alongside the divider.
  logic        dv_v   [DLY];
  logic [3:0]  dv_op  [DLY];
  logic [31:0] dv_val [DLY];
  logic        dv_flg [DLY];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLY; i++) dv_v[i] <= 1'b0;
    end else begin
      dv_v[0] <= v0;
      for (int i = 1; i < DLY; i++) dv_v[i] <= dv_v[i-1];
    end
    dv_op[0]  <= op0;
    dv_val[0] <= sval;
    dv_flg[0] <= sflag;
    for (int i = 1; i < DLY; i++) begin
      dv_op[i]  <= dv_op[i-1];
      dv_val[i] <= dv_val[i-1];
      dv_flg[i] <= dv_flg[i-1];
    end
  end

  // Multiplier, then delay its result to line up with the divider.
  fpa_pkg::res_t mul_res;
  fpa_pkg::res_t mul_d [DLY-MUL_LAT];
  fpa_pkg::res_t div_res;

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .a   (a0),
    .b   (b0),
    .res (mul_res)
  );

  always_ff @(posedge clk) begin
    mul_d[0] <= mul_res;
    for (int i = 1; i < DLY - MUL_LAT; i++) mul_d[i] <= mul_d[i-1];
  end

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .a   (a0),
    .b   (b0),
    .res (div_res)
  );

  // Result register: pick the path by op and drop the beat out for one cycle.
  logic [31:0] out_val_next;
  logic        out_flg_next;
  logic [1:0]  out_err_next;

  always_comb begin
    out_val_next = dv_val[DLY-1];
    out_flg_next = dv_flg[DLY-1];
    out_err_next = fpa_pkg::ERR_OK;
    case (fpa_pkg::op_t'(dv_op[DLY-1]))
      fpa_pkg::OP_MUL: begin
        out_val_next = mul_d[DLY-MUL_LAT-1].val;
        out_err_next = mul_d[DLY-MUL_LAT-1].err;
      end
      fpa_pkg::OP_DIV: begin
        out_val_next = div_res.val;
        out_err_next = div_res.err;
      end
      default: begin
        out_val_next = dv_val[DLY-1];
        out_err_next = fpa_pkg::ERR_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_v[DLY-1];
    end
    result_value <= out_val_next;
    compare_flag <= out_flg_next;
    error_code   <= out_err_next;
  end

endmodule
